@@ rtl/pip_loc_pkg.sv @@
// ----------------------------------------------------------------------------
// pip_loc_pkg
// Shared types and constants of the point-in-polygon locator.
// ----------------------------------------------------------------------------
package pip_loc_pkg;

   localparam int DEF_MAX_VERTICES        = 1024;
   localparam int DEF_MAX_POLYGONS        = 256;
   localparam int DEF_CORNERS_PER_POLYGON = 8;

   localparam int ACTION_W   = 2;
   localparam int VSLOT_W    = 10;
   localparam int PSLOT_W    = 8;
   localparam int CSLOT_W    = 3;
   localparam int TOTAL_W    = 4;
   localparam int COORD_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int SCAN_W     = 9;
   localparam int TOL_W      = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOL_W-1:0] TOL_RESET = 16'd66;
   localparam int MIN_CORNERS = 3;

   typedef enum logic [ACTION_W-1:0] {
      ACT_VERTEX = 2'd0,
      ACT_CORNER = 2'd1,
      ACT_LOCATE = 2'd2
   } action_type;

   typedef enum logic [0:0] {
      REG_SCAN = 1'b0,
      REG_TOL  = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CNT_RD,
      ST_CNT_WAIT,
      ST_FETCH,
      ST_DRAIN,
      ST_NEXT,
      ST_DONE
   } state_type;

endpackage

@@ rtl/pip_loc_ram.sv @@
// ----------------------------------------------------------------------------
// pip_loc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pip_loc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/point_in_polygon_locator.sv @@
// ----------------------------------------------------------------------------
// point_in_polygon_locator
// Stores vertices and polygon corner lists in RAM and locates a query point
// by an XYZ bounding-box test and an XZ crossing-parity or corner-nearness test.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             contents
//  req_*     in         req_valid/req_stall   vertex, corner or locate request
//  rsp_*     out        rsp_valid/rsp_stall   found flag and polygon index
//  csr       in/out     APB psel/penable      scan length, corner tolerance
//
//  load requests write the RAMs as they are taken; a locate reads, for each
//  scanned polygon with three or more corners, one corner-table entry per
//  cycle into the edge pipeline.
//  after reset the corner-count RAM is cleared with stall high.
//  a result waits in the output register; a new request is taken meanwhile.
// ----------------------------------------------------------------------------
module point_in_polygon_locator
   import pip_loc_pkg::*;
#(
   parameter int MAX_VERTICES        = DEF_MAX_VERTICES,
   parameter int MAX_POLYGONS        = DEF_MAX_POLYGONS,
   parameter int CORNERS_PER_POLYGON = DEF_CORNERS_PER_POLYGON
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [VSLOT_W-1:0]    req_vertex_slot,
   input  logic [PSLOT_W-1:0]    req_polygon_slot,
   input  logic [CSLOT_W-1:0]    req_corner_slot,
   input  logic [TOTAL_W-1:0]    req_corner_total,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_found,
   output logic [INDEX_W-1:0]    rsp_polygon_index,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int VA_W   = $clog2(MAX_VERTICES);
   localparam int PA_W   = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
   localparam int PN_W   = $clog2(MAX_POLYGONS + 1);
   localparam int CD     = MAX_POLYGONS * CORNERS_PER_POLYGON;
   localparam int CA_W   = $clog2(CD);
   localparam int K_W    = $clog2(CORNERS_PER_POLYGON);
   localparam int N_W    = $clog2(CORNERS_PER_POLYGON + 1);
   localparam int VD_W   = 3 * COORD_W;
   localparam int D_W    = COORD_W + 1;
   localparam int P_W    = 2 * D_W;

   // ---------------- configuration registers
   logic [SCAN_W-1:0] scan_cfg_ff, scan_cfg_in;
   logic [TOL_W-1:0]  tol_ff, tol_in;
   logic              csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      scan_cfg_in = scan_cfg_ff;
      tol_in      = tol_ff;
      if (csr_write) begin
         case (reg_index_type'(paddr[2]))
            REG_SCAN: scan_cfg_in = pwdata[SCAN_W-1:0];
            REG_TOL:  tol_in      = pwdata[TOL_W-1:0];
            default:  ;
         endcase
      end
   end

   always_comb begin
      case (reg_index_type'(paddr[2]))
         REG_SCAN: prdata = CSR_DATA_W'(scan_cfg_ff);
         REG_TOL:  prdata = CSR_DATA_W'(tol_ff);
         default:  prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cfg_ff <= '0;
         tol_ff      <= TOL_RESET;
      end else begin
         scan_cfg_ff <= scan_cfg_in;
         tol_ff      <= tol_in;
      end
   end

   // ---------------- memories
   logic              vtx_we;
   logic [VA_W-1:0]   vtx_waddr, vtx_raddr;
   logic [VD_W-1:0]   vtx_wdata, vtx_rdata;
   logic              cor_we;
   logic [CA_W-1:0]   cor_waddr, cor_raddr;
   logic [VSLOT_W-1:0] cor_rdata;
   logic              cnt_we;
   logic [PA_W-1:0]   cnt_waddr, cnt_raddr;
   logic [N_W-1:0]    cnt_wdata, cnt_rdata;

   pip_loc_ram #(.WIDTH(VD_W), .DEPTH(MAX_VERTICES)) u_vertex_ram (
      .clock(clock), .wr_en(vtx_we), .wr_addr(vtx_waddr), .wr_data(vtx_wdata),
      .rd_addr(vtx_raddr), .rd_data(vtx_rdata)
   );

   pip_loc_ram #(.WIDTH(VSLOT_W), .DEPTH(CD)) u_corner_ram (
      .clock(clock), .wr_en(cor_we), .wr_addr(cor_waddr), .wr_data(req_vertex_slot),
      .rd_addr(cor_raddr), .rd_data(cor_rdata)
   );

   pip_loc_ram #(.WIDTH(N_W), .DEPTH(MAX_POLYGONS)) u_count_ram (
      .clock(clock), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
      .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
   );

   // ---------------- control state
   state_type         state_ff, state_in;
   logic [PA_W-1:0]   clr_ff, clr_in;
   logic [PA_W-1:0]   poly_ff, poly_in;
   logic [PN_W-1:0]   npoly_ff, npoly_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [N_W-1:0]    ncor_ff, ncor_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic              res_found_ff, res_found_in;
   logic [INDEX_W-1:0] res_index_ff, res_index_in;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic              accept, start_poly, issue;
   logic              s0_v_ff, s0_last_ff, s1_v_ff, s1_last_ff, s1_zero_ff;
   logic              close_ff, e0_v_ff, e1_v_ff, e2_v_ff;
   logic              busy, poly_hit;
   logic [N_W-1:0]    cnt_sat;
   logic [N_W-1:0]    total_sat;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;
   assign rsp_polygon_index = rsp_index_ff;

   assign total_sat = (32'(req_corner_total) > CORNERS_PER_POLYGON) ?
                      N_W'(CORNERS_PER_POLYGON) : N_W'(req_corner_total);
   assign cnt_sat   = (32'(cnt_rdata) > CORNERS_PER_POLYGON) ?
                      N_W'(CORNERS_PER_POLYGON) : cnt_rdata;
   assign busy      = s0_v_ff || s1_v_ff || close_ff || e0_v_ff || e1_v_ff || e2_v_ff;

   // load and clear writes, table read addresses
   always_comb begin
      vtx_we    = accept && (req_action == ACT_VERTEX) &&
                  (32'(req_vertex_slot) < MAX_VERTICES);
      vtx_waddr = VA_W'(req_vertex_slot);
      vtx_wdata = {req_coord_x, req_coord_y, req_coord_z};
      cor_we    = accept && (req_action == ACT_CORNER) &&
                  (32'(req_polygon_slot) < MAX_POLYGONS) &&
                  (32'(req_corner_slot) < CORNERS_PER_POLYGON);
      cor_waddr = CA_W'(32'(req_polygon_slot) * CORNERS_PER_POLYGON + 32'(req_corner_slot));
      if (state_ff == ST_CLEAR) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ff;
         cnt_wdata = '0;
      end else begin
         cnt_we    = cor_we;
         cnt_waddr = PA_W'(req_polygon_slot);
         cnt_wdata = total_sat;
      end
      cnt_raddr = poly_ff;
      cor_raddr = CA_W'(32'(poly_ff) * CORNERS_PER_POLYGON + 32'(k_ff));
      vtx_raddr = VA_W'(cor_rdata);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      poly_in      = poly_ff;
      npoly_in     = npoly_ff;
      k_in         = k_ff;
      ncor_in      = ncor_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      res_found_in = res_found_ff;
      res_index_in = res_index_ff;
      start_poly   = 1'b0;
      issue        = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == MAX_POLYGONS - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && req_action == ACT_LOCATE) begin
               poly_in      = '0;
               npoly_in     = (32'(scan_cfg_ff) > MAX_POLYGONS) ?
                              PN_W'(MAX_POLYGONS) : PN_W'(scan_cfg_ff);
               res_found_in = 1'b0;
               res_index_in = '0;
               state_in     = (scan_cfg_ff == '0) ? ST_DONE : ST_CNT_RD;
            end
         end
         ST_CNT_RD: state_in = ST_CNT_WAIT;
         ST_CNT_WAIT: begin
            if (32'(cnt_sat) < MIN_CORNERS) begin
               state_in = ST_NEXT;
            end else begin
               ncor_in    = cnt_sat;
               k_in       = '0;
               start_poly = 1'b1;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            issue = 1'b1;
            k_in  = k_ff + 1'b1;
            if (32'(k_ff) + 1 == 32'(ncor_ff)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!busy) begin
               if (poly_hit) begin
                  res_found_in = 1'b1;
                  res_index_in = INDEX_W'(poly_ff);
                  state_in     = ST_DONE;
               end else begin
                  state_in = ST_NEXT;
               end
            end
         end
         ST_NEXT: begin
            if (32'(poly_ff) + 1 == 32'(npoly_ff)) begin
               state_in = ST_DONE;
            end else begin
               poly_in  = poly_ff + 1'b1;
               state_in = ST_CNT_RD;
            end
         end
         ST_DONE: begin
            // the previous result stays put until it has been taken
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_index_in = res_index_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      poly_ff      <= poly_in;
      npoly_ff     <= npoly_in;
      k_ff         <= k_in;
      ncor_ff      <= ncor_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      res_found_ff <= res_found_in;
      res_index_ff <= res_index_in;
      if (accept) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
         pz_ff <= req_coord_z;
      end
   end

   // ---------------- corner stream
   logic signed [COORD_W-1:0] cx, cy, cz;
   logic signed [COORD_W-1:0] lx_ff, hx_ff, ly_ff, hy_ff, lz_ff, hz_ff;
   logic signed [COORD_W-1:0] fx_ff, fz_ff, qx_ff, qz_ff;
   logic signed [COORD_W-1:0] ix_ff, iz_ff, jx_ff, jz_ff;
   logic              first_ff, near_ff, odd_ff;
   logic signed [D_W-1:0] ddx, ddz;
   logic [D_W-1:0]    mdx, mdz;
   logic              near_now;

   assign cx = s1_zero_ff ? '0 : $signed(vtx_rdata[3*COORD_W-1:2*COORD_W]);
   assign cy = s1_zero_ff ? '0 : $signed(vtx_rdata[2*COORD_W-1:COORD_W]);
   assign cz = s1_zero_ff ? '0 : $signed(vtx_rdata[COORD_W-1:0]);

   assign ddx = D_W'(cx) - D_W'(px_ff);
   assign ddz = D_W'(cz) - D_W'(pz_ff);
   assign mdx = ddx[D_W-1] ? D_W'(-ddx) : D_W'(ddx);
   assign mdz = ddz[D_W-1] ? D_W'(-ddz) : D_W'(ddz);
   assign near_now = (mdx < D_W'(tol_ff)) && (mdz < D_W'(tol_ff));

   assign poly_hit = (px_ff >= lx_ff) && (px_ff <= hx_ff) &&
                     (py_ff >= ly_ff) && (py_ff <= hy_ff) &&
                     (pz_ff >= lz_ff) && (pz_ff <= hz_ff) && (near_ff || odd_ff);

   // edge pipeline
   logic signed [D_W-1:0] ea_ff, eb_ff, ec_ff, ed_ff;
   logic              e1_cross_ff, e1_pos_ff, e2_cross_ff, e2_pos_ff;
   logic signed [P_W-1:0] p1_ff, p2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff  <= 1'b0;
         s1_v_ff  <= 1'b0;
         close_ff <= 1'b0;
         e0_v_ff  <= 1'b0;
         e1_v_ff  <= 1'b0;
         e2_v_ff  <= 1'b0;
      end else begin
         s0_v_ff  <= issue;
         s1_v_ff  <= s0_v_ff;
         close_ff <= s1_v_ff && s1_last_ff;
         e0_v_ff  <= (s1_v_ff && !first_ff) || close_ff;
         e1_v_ff  <= e0_v_ff;
         e2_v_ff  <= e1_v_ff;
      end
      s0_last_ff <= (32'(k_ff) + 1 == 32'(ncor_ff));
      s1_last_ff <= s0_last_ff;
      s1_zero_ff <= (32'(cor_rdata) >= MAX_VERTICES);

      if (start_poly) begin
         first_ff <= 1'b1;
         near_ff  <= 1'b0;
      end else if (s1_v_ff) begin
         first_ff <= 1'b0;
         near_ff  <= near_ff || near_now;
         qx_ff    <= cx;
         qz_ff    <= cz;
         if (first_ff) begin
            lx_ff <= cx; hx_ff <= cx;
            ly_ff <= cy; hy_ff <= cy;
            lz_ff <= cz; hz_ff <= cz;
            fx_ff <= cx; fz_ff <= cz;
         end else begin
            if (cx < lx_ff) lx_ff <= cx;
            if (cx > hx_ff) hx_ff <= cx;
            if (cy < ly_ff) ly_ff <= cy;
            if (cy > hy_ff) hy_ff <= cy;
            if (cz < lz_ff) lz_ff <= cz;
            if (cz > hz_ff) hz_ff <= cz;
         end
      end

      // edge endpoints: consecutive corners, then last back to first
      if (close_ff) begin
         ix_ff <= qx_ff; iz_ff <= qz_ff;
         jx_ff <= fx_ff; jz_ff <= fz_ff;
      end else begin
         ix_ff <= qx_ff; iz_ff <= qz_ff;
         jx_ff <= cx;    jz_ff <= cz;
      end

      ea_ff       <= D_W'(px_ff) - D_W'(ix_ff);
      eb_ff       <= D_W'(jz_ff) - D_W'(iz_ff);
      ec_ff       <= D_W'(jx_ff) - D_W'(ix_ff);
      ed_ff       <= D_W'(pz_ff) - D_W'(iz_ff);
      e1_cross_ff <= ((iz_ff <= pz_ff) && (jz_ff > pz_ff)) ||
                     ((jz_ff <= pz_ff) && (iz_ff > pz_ff));
      e1_pos_ff   <= (jz_ff > iz_ff);

      p1_ff       <= ea_ff * eb_ff;
      p2_ff       <= ec_ff * ed_ff;
      e2_cross_ff <= e1_cross_ff;
      e2_pos_ff   <= e1_pos_ff;

      if (start_poly) begin
         odd_ff <= 1'b0;
      end else if (e2_v_ff && e2_cross_ff &&
                   ((e2_pos_ff && (p1_ff < p2_ff)) || (!e2_pos_ff && (p1_ff > p2_ff)))) begin
         odd_ff <= !odd_ff;
      end
   end

   // ---------------- checks
   a_clear_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> req_stall)
      else $error("request taken during count clear");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_polygon_index == '0))
      else $error("miss reported with non-zero index");

   a_edge_in_scan: assert property (@(posedge clock) disable iff (reset)
      e2_v_ff |-> (state_ff == ST_FETCH || state_ff == ST_DRAIN))
      else $error("edge pipeline active outside a polygon scan");

   a_close_alone: assert property (@(posedge clock) disable iff (reset)
      close_ff |-> !s1_v_ff)
      else $error("closing edge overlaps a corner");

   a_decide_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && state_in != ST_DRAIN) |-> !busy)
      else $error("polygon decided before edge pipeline drained");

endmodule
